// ===== design/trr_pkg.sv =====
// Shared types and constants of the triangle tile rasterizer.
package trr_pkg;

  localparam int unsigned VW    = 16;  // vertex coordinate width, signed 12.4
  localparam int unsigned CW    = 17;  // edge step coefficient width
  localparam int unsigned EW    = 40;  // edge value width
  localparam int unsigned PW    = 6;   // pixel coordinate width
  localparam int unsigned RW    = 7;   // clip register width
  localparam int unsigned NPROD = 14;  // products formed during setup

  localparam int unsigned IN_DW  = 6 * VW;
  localparam int unsigned OUT_DW = 24;

  // configuration register indexes
  localparam logic REG_CLIP_WIDTH  = 1'b0;
  localparam logic REG_CLIP_HEIGHT = 1'b1;

  // one set-up triangle, handed from setup to scan
  typedef struct packed {
    logic                     empty;
    logic [PW-1:0]            box_x0;
    logic [PW-1:0]            box_y0;
    logic [PW-1:0]            box_x1;
    logic [PW-1:0]            box_y1;
    logic [2:0][CW-1:0]       coef_a;
    logic [2:0][CW-1:0]       coef_b;
    logic [2:0][EW-1:0]       start;
  } trr_job_t;

  // round 12.4 to the nearest whole pixel, halves away from zero
  function automatic logic signed [12:0] round_12_4(input logic signed [VW-1:0] v);
    logic [VW:0] mag;
    logic [VW:0] r;
    mag = v[VW-1] ? (VW+1)'(-$signed({v[VW-1], v})) : {1'b0, v};
    r = (mag + (VW+1)'(8)) >> 4;
    return v[VW-1] ? -$signed(r[12:0]) : $signed(r[12:0]);
  endfunction

endpackage

// ===== design/trr_setup.sv =====
// Triangle setup: bounding box, clipping, edge start values and area.
module trr_setup #(
  parameter int TILE_DIM = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [trr_pkg::IN_DW-1:0]    in_tdata,
  input  logic [trr_pkg::RW-1:0]       clip_width,
  input  logic [trr_pkg::RW-1:0]       clip_height,
  output logic                         job_valid,
  input  logic                         job_ready,
  output trr_pkg::trr_job_t            job
);
  import trr_pkg::*;

  localparam logic [RW-1:0] TILE_LIM = RW'(TILE_DIM);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_BOX  = 4'b0010,
    S_MUL  = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [VW-1:0] vx_r [3];
  logic signed [VW-1:0] vy_r [3];
  logic signed [CW-1:0] dx_r [3];
  logic signed [CW-1:0] dy_r [3];
  logic [PW-1:0] bx0_r, by0_r, bx1_r, by1_r;
  logic          box_empty_r;
  logic [3:0]    step_r;
  logic signed [35:0] prod_r;
  logic [1:0]    dest_r;
  logic          neg_r;
  logic          pvalid_r;
  logic signed [EW-1:0] acc_r [4];

  // box arithmetic
  logic signed [VW-1:0] minx, miny, maxx, maxy;
  logic signed [12:0]   rx0, ry0, rx1, ry1, cx0, cy0, cx1, cy1, limx, limy;
  logic [RW-1:0]        cwid, chgt;

  // multiplier operands
  logic signed [17:0] opa, opb;
  logic               neg_c;
  logic [1:0]         ei;
  logic [9:0]         px0, py0;

  function automatic logic signed [VW-1:0] min3(input logic signed [VW-1:0] a,
      input logic signed [VW-1:0] b, input logic signed [VW-1:0] c);
    logic signed [VW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [VW-1:0] max3(input logic signed [VW-1:0] a,
      input logic signed [VW-1:0] b, input logic signed [VW-1:0] c);
    logic signed [VW-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  always_comb begin
    minx = min3(vx_r[0], vx_r[1], vx_r[2]);
    miny = min3(vy_r[0], vy_r[1], vy_r[2]);
    maxx = max3(vx_r[0], vx_r[1], vx_r[2]);
    maxy = max3(vy_r[0], vy_r[1], vy_r[2]);
    rx0 = round_12_4(minx);
    ry0 = round_12_4(miny);
    rx1 = round_12_4(maxx);
    ry1 = round_12_4(maxy);
    cwid = (clip_width == '0) ? RW'(1) : ((clip_width > TILE_LIM) ? TILE_LIM : clip_width);
    chgt = (clip_height == '0) ? RW'(1) : ((clip_height > TILE_LIM) ? TILE_LIM : clip_height);
    limx = $signed({6'b0, RW'(cwid - RW'(1))});
    limy = $signed({6'b0, RW'(chgt - RW'(1))});
    cx0 = (rx0 < 0) ? 13'sd0 : rx0;
    cy0 = (ry0 < 0) ? 13'sd0 : ry0;
    cx1 = (rx1 > limx) ? limx : rx1;
    cy1 = (ry1 > limy) ? limy : ry1;
  end

  // pixel centers of the box corner, 12.4
  assign px0 = {bx0_r, 4'b1000};
  assign py0 = {by0_r, 4'b1000};

  // product schedule: four per edge, then two for the area
  always_comb begin
    ei    = step_r[3:2];
    opa   = '0;
    opb   = '0;
    neg_c = 1'b0;
    if (step_r[3:2] == 2'd3) begin
      if (step_r[1:0] == 2'd0) begin
        opa = 18'(dy_r[0]);
        opb = 18'(dx_r[2]);
      end else begin
        opa   = 18'(dx_r[0]);
        opb   = 18'(dy_r[2]);
        neg_c = 1'b1;
      end
    end else begin
      case (step_r[1:0])
        2'd0: begin
          opa = 18'(dy_r[ei]);
          opb = $signed({8'b0, px0});
        end
        2'd1: begin
          opa   = 18'(dx_r[ei]);
          opb   = $signed({8'b0, py0});
          neg_c = 1'b1;
        end
        2'd2: begin
          opa = 18'(vy_r[ei]);
          opb = 18'(dx_r[ei]);
        end
        default: begin
          opa   = 18'(vx_r[ei]);
          opb   = 18'(dy_r[ei]);
          neg_c = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_BOX;
      S_BOX:   state_nxt = S_MUL;
      S_MUL:   if (step_r == 4'(NPROD)) state_nxt = S_PUSH;
      S_PUSH:  if (job_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pvalid_r <= 1'b0;
      step_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      pvalid_r <= (state_r == S_MUL) && (step_r < 4'(NPROD));
      if (state_r == S_BOX) begin
        step_r <= '0;
      end else if (state_r == S_MUL) begin
        step_r <= step_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      for (int i = 0; i < 3; i++) begin
        vx_r[i] <= in_tdata[(2*i)*VW +: VW];
        vy_r[i] <= in_tdata[(2*i+1)*VW +: VW];
      end
    end
    if (state_r == S_BOX) begin
      for (int i = 0; i < 3; i++) begin
        dx_r[i] <= CW'(vx_r[(i+1)%3]) - CW'(vx_r[i]);
        dy_r[i] <= CW'(vy_r[(i+1)%3]) - CW'(vy_r[i]);
      end
      bx0_r       <= cx0[PW-1:0];
      by0_r       <= cy0[PW-1:0];
      bx1_r       <= cx1[PW-1:0];
      by1_r       <= cy1[PW-1:0];
      box_empty_r <= (cx0 > cx1) || (cy0 > cy1);
      for (int i = 0; i < 4; i++) acc_r[i] <= '0;
    end
    prod_r <= opa * opb;
    dest_r <= (step_r[3:2] == 2'd3) ? 2'd3 : ei;
    neg_r  <= neg_c;
    if (pvalid_r) begin
      acc_r[dest_r] <= neg_r ? acc_r[dest_r] - EW'(prod_r) : acc_r[dest_r] + EW'(prod_r);
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign job_valid = (state_r == S_PUSH);

  always_comb begin
    job.empty  = box_empty_r || (acc_r[3] == '0);
    job.box_x0 = bx0_r;
    job.box_y0 = by0_r;
    job.box_x1 = bx1_r;
    job.box_y1 = by1_r;
    for (int i = 0; i < 3; i++) begin
      job.coef_a[i] = dy_r[i];
      job.coef_b[i] = -dx_r[i];
      job.start[i]  = acc_r[i];
    end
  end

endmodule

// ===== design/trr_queue.sv =====
// Two-entry queue of set-up triangles between setup and scan.
module trr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  trr_pkg::trr_job_t  push_job,
  output logic               pop_valid,
  input  logic               pop_ready,
  output trr_pkg::trr_job_t  pop_job
);
  import trr_pkg::*;

  localparam int unsigned DEPTH = 2;

  trr_job_t  mem_r [DEPTH];
  logic      wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic      do_push, do_pop;

  assign push_ready = (cnt_r != 2'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= ~wptr_r;
      if (do_pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_job;
  end

endmodule

// ===== design/trr_scan.sv =====
// Row scan: walks each pixel of the box and emits one span per row.
module trr_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  trr_pkg::trr_job_t             job,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [trr_pkg::OUT_DW-1:0]    out_tdata,
  output logic                          out_tlast
);
  import trr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic signed [EW-1:0] stepx_r [3];
  logic signed [EW-1:0] stepy_r [3];
  logic signed [EW-1:0] rs_r [3];
  logic signed [EW-1:0] cur_r [3];
  logic [PW-1:0] x_r, y_r, bx0_r, bx1_r, by1_r;
  logic [PW-1:0] first_r, last_r;
  logic          found_r, empty_r;

  logic          out_valid_r, out_last_r, out_span_r;
  logic [PW-1:0] out_row_r, out_first_r, out_last_x_r;

  logic covered, all_ge, all_le, out_free, row_done, tri_done;

  always_comb begin
    all_ge = 1'b1;
    all_le = 1'b1;
    for (int i = 0; i < 3; i++) begin
      all_ge = all_ge && (cur_r[i] >= 0);
      all_le = all_le && (cur_r[i] <= 0);
    end
    covered = all_ge || all_le;
  end

  assign out_free  = !out_valid_r || out_tready;
  assign job_ready = (state_r == S_IDLE);
  assign row_done  = (x_r == bx1_r);
  assign tri_done  = empty_r || (y_r == by1_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (job_valid) state_nxt = job.empty ? S_EMIT : S_SCAN;
      S_SCAN:  if (row_done) state_nxt = S_EMIT;
      S_EMIT:  if (out_free) state_nxt = tri_done ? S_IDLE : S_SCAN;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          for (int i = 0; i < 3; i++) begin
            stepx_r[i] <= EW'($signed(job.coef_a[i])) <<< 4;
            stepy_r[i] <= EW'($signed(job.coef_b[i])) <<< 4;
            rs_r[i]    <= job.start[i];
            cur_r[i]   <= job.start[i];
          end
          x_r     <= job.box_x0;
          bx0_r   <= job.box_x0;
          bx1_r   <= job.box_x1;
          by1_r   <= job.box_y1;
          empty_r <= job.empty;
          y_r     <= job.empty ? '0 : job.box_y0;
          found_r <= 1'b0;
          first_r <= '0;
          last_r  <= '0;
        end
      end
      S_SCAN: begin
        if (covered) begin
          if (!found_r) first_r <= x_r;
          last_r  <= x_r;
          found_r <= 1'b1;
        end
        for (int i = 0; i < 3; i++) cur_r[i] <= cur_r[i] + stepx_r[i];
        if (!row_done) x_r <= x_r + PW'(1);
      end
      S_EMIT: begin
        if (out_free) begin
          out_row_r    <= y_r;
          out_first_r  <= first_r;
          out_last_x_r <= last_r;
          out_span_r   <= found_r;
          out_last_r   <= tri_done;
          // advance to the next row
          for (int i = 0; i < 3; i++) begin
            rs_r[i]  <= rs_r[i] + stepy_r[i];
            cur_r[i] <= rs_r[i] + stepy_r[i];
          end
          y_r     <= y_r + PW'(1);
          x_r     <= bx0_r;
          found_r <= 1'b0;
          first_r <= '0;
          last_r  <= '0;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'b0, out_span_r, out_last_x_r, out_first_r, out_row_r};

endmodule

// ===== design/triangle_tile_rasterizer.sv =====
// Top level of the triangle tile rasterizer: configuration registers and the three stages.
//
// Each request on the input stream is one triangle (three vertices, signed 12.4). The
// block answers with one span per row of the triangle's pixel-rounded bounding box
// clipped to the clip_width x clip_height tile, top row first, tlast on the final row;
// a zero-area or fully clipped triangle gives a single empty span with tlast set. A
// setup stage runs the edge and area products of each triangle through one shared
// multiplier and hands the result to a two-entry queue. The scan stage then steps
// across each pixel of the clipped box width in turn and hands off one span at the end
// of each row, waiting while the output register holds a span not yet taken; setup of
// the next triangle overlaps with the scan of the current one. An output register
// decouples the scan from the result stream. Write the clip registers only while no
// triangle is in flight.
module triangle_tile_rasterizer #(
  parameter int TILE_DIM = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y (16 bits each)
  input  logic [trr_pkg::IN_DW-1:0]     in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // row_index[5:0], span_first_x[11:6], span_last_x[17:12], span_valid[18], zero pad
  output logic [trr_pkg::OUT_DW-1:0]    out_tdata,
  output logic                          out_tlast,   // last_row
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [trr_pkg::RW-1:0]        cfg_wdata
);
  import trr_pkg::*;

  logic [RW-1:0] clip_width_r, clip_height_r;
  logic          setup_valid, setup_ready, q_valid, q_ready;
  trr_job_t      setup_job, q_job;

  // clip registers reset to 64, the full tile for the default TILE_DIM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_width_r  <= RW'(64);
      clip_height_r <= RW'(64);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CLIP_WIDTH:  clip_width_r  <= cfg_wdata;
        REG_CLIP_HEIGHT: clip_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  trr_setup #(.TILE_DIM(TILE_DIM)) u_setup (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .clip_width (clip_width_r),
    .clip_height(clip_height_r),
    .job_valid  (setup_valid),
    .job_ready  (setup_ready),
    .job        (setup_job)
  );

  trr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(setup_valid),
    .push_ready(setup_ready),
    .push_job  (setup_job),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_job   (q_job)
  );

  trr_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
